[hw/rtl/vsau_pkg.sv]
`timescale 1ns / 1ps
// vsau_pkg: shared types, operation and register codes, and address constants
// for the video scroll address unit; no dependencies

package vsau_pkg;

    // widths of the transaction fields
    localparam int OP_W     = 3;
    localparam int SEL_W    = 3;
    localparam int DATA_W   = 8;
    localparam int ADDR_W   = 15;
    localparam int VADDR_W  = 14;
    localparam int FINE_W   = 3;
    localparam int ACCESS_W = 2;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [VADDR_W-1:0] vaddr_t;

    // operation codes
    localparam logic [OP_W-1:0] OP_REG_WRITE  = 3'd0;
    localparam logic [OP_W-1:0] OP_REG_READ   = 3'd1;
    localparam logic [OP_W-1:0] OP_COARSE_X   = 3'd2;
    localparam logic [OP_W-1:0] OP_STEP_Y     = 3'd3;
    localparam logic [OP_W-1:0] OP_COPY_HORIZ = 3'd4;
    localparam logic [OP_W-1:0] OP_COPY_VERT  = 3'd5;

    // cpu register indexes
    localparam logic [SEL_W-1:0] REG_CONTROL = 3'd0;
    localparam logic [SEL_W-1:0] REG_MASK    = 3'd1;
    localparam logic [SEL_W-1:0] REG_STATUS  = 3'd2;
    localparam logic [SEL_W-1:0] REG_SCROLL  = 3'd5;
    localparam logic [SEL_W-1:0] REG_ADDRESS = 3'd6;
    localparam logic [SEL_W-1:0] REG_DATA    = 3'd7;

    // data port access codes
    localparam logic [ACCESS_W-1:0] ACCESS_NONE  = 2'd0;
    localparam logic [ACCESS_W-1:0] ACCESS_READ  = 2'd1;
    localparam logic [ACCESS_W-1:0] ACCESS_WRITE = 2'd2;

    // address constants
    localparam addr_t  HORIZ_BITS    = 15'h041F;
    localparam addr_t  VERT_BITS     = 15'h7BE0;
    localparam addr_t  FINE_Y_ONE    = 15'h1000;
    localparam addr_t  ROW_STEP      = 15'd32;
    localparam vaddr_t TILE_BASE     = 14'h2000;
    localparam vaddr_t ATTR_BASE     = 14'h23C0;
    localparam logic [4:0] COARSE_MAX  = 5'd31;
    localparam logic [4:0] COARSE_Y_NT = 5'd29;
    localparam logic [2:0] FINE_Y_MAX  = 3'd7;

endpackage

[hw/rtl/video_scroll_address_unit.sv]
`timescale 1ns / 1ps
// video_scroll_address_unit: scroll and video address registers of a tile video
// processor; depends on vsau_pkg
//
// stages: input register, then result register; the state update is combinational
// logic from the input register into the address registers and the result register
// throughput: one transaction per cycle unless the output stalls
// reset: asynchronous, active low; clears both addresses, fine x, the write
// toggle, the increment mode, the rendering enables and both valid flags

module video_scroll_address_unit
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [vsau_pkg::OP_W-1:0]     operation,
    input  logic [vsau_pkg::SEL_W-1:0]    reg_select,
    input  logic [vsau_pkg::DATA_W-1:0]   write_data,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [vsau_pkg::ADDR_W-1:0]   current_address,
    output logic [vsau_pkg::FINE_W-1:0]   fine_scroll_x,
    output logic [vsau_pkg::ACCESS_W-1:0] data_access,
    output logic [vsau_pkg::VADDR_W-1:0]  access_address,
    output logic [vsau_pkg::DATA_W-1:0]   access_data,
    output logic [vsau_pkg::VADDR_W-1:0]  tile_address,
    output logic [vsau_pkg::VADDR_W-1:0]  attribute_address
);
    import vsau_pkg::*;

    // input register
    logic              s1_valid_reg;
    logic [OP_W-1:0]   op_reg;
    logic [SEL_W-1:0]  sel_reg;
    logic [DATA_W-1:0] data_reg;

    // architectural state
    addr_t             vaddr_reg, vaddr_next;
    addr_t             taddr_reg, taddr_next;
    logic [FINE_W-1:0] fine_x_reg, fine_x_next;
    logic              toggle_reg, toggle_next;
    logic              inc_row_reg, inc_row_next;
    logic [1:0]        render_reg, render_next;

    // result register
    logic                out_valid_reg;
    addr_t               cur_addr_reg;
    logic [FINE_W-1:0]   fine_out_reg;
    logic [ACCESS_W-1:0] access_reg, access_next;
    vaddr_t              acc_addr_reg, acc_addr_next;
    logic [DATA_W-1:0]   acc_data_reg, acc_data_next;
    vaddr_t              tile_reg, tile_next;
    vaddr_t              attr_reg, attr_next;

    // step helpers
    logic       s1_advance;
    logic       rendering;
    addr_t      data_step_addr;
    addr_t      coarse_x_addr;
    addr_t      step_y_addr;
    logic [4:0] cy_next;
    logic       nt_flip;

    // the stage moves when the result register is free or being drained
    assign s1_advance = !out_valid_reg || !out_stall;
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign rendering  = (render_reg != 2'b00);

    // data port increment by one or by a row, wrapping in 15 bits
    assign data_step_addr = vaddr_reg + (inc_row_reg ? ROW_STEP : addr_t'(1));

    // coarse x step with horizontal nametable flip
    always_comb
    begin
        if (vaddr_reg[4:0] == COARSE_MAX)
        begin
            coarse_x_addr = {vaddr_reg[14:11], ~vaddr_reg[10], vaddr_reg[9:5], 5'b00000};
        end
        else
        begin
            coarse_x_addr = vaddr_reg + addr_t'(1);
        end
    end

    // y step: fine y first, then coarse y with flip at 29 and wrap at 31
    always_comb
    begin
        nt_flip = (vaddr_reg[9:5] == COARSE_Y_NT);
        if (nt_flip || vaddr_reg[9:5] == COARSE_MAX)
        begin
            cy_next = 5'd0;
        end
        else
        begin
            cy_next = vaddr_reg[9:5] + 5'd1;
        end
        if (vaddr_reg[14:12] != FINE_Y_MAX)
        begin
            step_y_addr = vaddr_reg + FINE_Y_ONE;
        end
        else
        begin
            step_y_addr = {3'b000, vaddr_reg[11] ^ nt_flip, vaddr_reg[10], cy_next,
                           vaddr_reg[4:0]};
        end
    end

    // next state and result for the transaction in the input register
    always_comb
    begin
        vaddr_next    = vaddr_reg;
        taddr_next    = taddr_reg;
        fine_x_next   = fine_x_reg;
        toggle_next   = toggle_reg;
        inc_row_next  = inc_row_reg;
        render_next   = render_reg;
        access_next   = ACCESS_NONE;
        acc_addr_next = '0;
        acc_data_next = '0;
        case (op_reg)
            OP_REG_WRITE:
            begin
                case (sel_reg)
                    REG_DATA:
                    begin
                        access_next   = ACCESS_WRITE;
                        acc_addr_next = vaddr_reg[VADDR_W-1:0];
                        acc_data_next = data_reg;
                        vaddr_next    = data_step_addr;
                    end
                    REG_CONTROL:
                    begin
                        inc_row_next       = data_reg[2];
                        taddr_next[11:10]  = data_reg[1:0];
                    end
                    REG_MASK:
                    begin
                        render_next = data_reg[4:3];
                    end
                    REG_SCROLL:
                    begin
                        if (!toggle_reg)
                        begin
                            fine_x_next      = data_reg[2:0];
                            taddr_next[4:0]  = data_reg[7:3];
                            toggle_next      = 1'b1;
                        end
                        else
                        begin
                            taddr_next[14:12] = data_reg[2:0];
                            taddr_next[9:5]   = data_reg[7:3];
                            toggle_next       = 1'b0;
                        end
                    end
                    REG_ADDRESS:
                    begin
                        if (!toggle_reg)
                        begin
                            taddr_next[14:8] = {1'b0, data_reg[5:0]};
                            toggle_next      = 1'b1;
                        end
                        else
                        begin
                            taddr_next  = {taddr_reg[14:8], data_reg};
                            vaddr_next  = {taddr_reg[14:8], data_reg};
                            toggle_next = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_REG_READ:
            begin
                if (sel_reg == REG_STATUS)
                begin
                    toggle_next = 1'b0;
                end
                else if (sel_reg == REG_DATA)
                begin
                    access_next   = ACCESS_READ;
                    acc_addr_next = vaddr_reg[VADDR_W-1:0];
                    vaddr_next    = data_step_addr;
                end
            end
            OP_COARSE_X:
            begin
                if (rendering)
                begin
                    vaddr_next = coarse_x_addr;
                end
            end
            OP_STEP_Y:
            begin
                if (rendering)
                begin
                    vaddr_next = step_y_addr;
                end
            end
            OP_COPY_HORIZ:
            begin
                if (rendering)
                begin
                    vaddr_next = (vaddr_reg & ~HORIZ_BITS) | (taddr_reg & HORIZ_BITS);
                end
            end
            OP_COPY_VERT:
            begin
                if (rendering)
                begin
                    vaddr_next = (vaddr_reg & ~VERT_BITS) | (taddr_reg & VERT_BITS);
                end
            end
            default:
            begin
            end
        endcase

        // fetch addresses from the updated current address
        tile_next = TILE_BASE | {2'b00, vaddr_next[11:0]};
        attr_next = ATTR_BASE | {2'b00, vaddr_next[11:10], 4'b0000, vaddr_next[9:7],
                                 vaddr_next[4:2]};
    end

    // input register, state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            vaddr_reg     <= '0;
            taddr_reg     <= '0;
            fine_x_reg    <= '0;
            toggle_reg    <= 1'b0;
            inc_row_reg   <= 1'b0;
            render_reg    <= 2'b00;
        end
        else
        begin
            // take a new transaction when the stage is empty or moving on
            if (!s1_valid_reg || s1_advance)
            begin
                s1_valid_reg <= in_valid;
                op_reg       <= operation;
                sel_reg      <= reg_select;
                data_reg     <= write_data;
            end

            // result valid: set by a commit, cleared by a drain
            if (s1_valid_reg && s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // commit the transaction in the input register
            if (s1_valid_reg && s1_advance)
            begin
                vaddr_reg     <= vaddr_next;
                taddr_reg     <= taddr_next;
                fine_x_reg    <= fine_x_next;
                toggle_reg    <= toggle_next;
                inc_row_reg   <= inc_row_next;
                render_reg    <= render_next;
                cur_addr_reg  <= vaddr_next;
                fine_out_reg  <= fine_x_next;
                access_reg    <= access_next;
                acc_addr_reg  <= acc_addr_next;
                acc_data_reg  <= acc_data_next;
                tile_reg      <= tile_next;
                attr_reg      <= attr_next;
            end
        end
    end

    // result outputs
    assign out_valid         = out_valid_reg;
    assign current_address   = cur_addr_reg;
    assign fine_scroll_x     = fine_out_reg;
    assign data_access       = access_reg;
    assign access_address    = acc_addr_reg;
    assign access_data       = acc_data_reg;
    assign tile_address      = tile_reg;
    assign attribute_address = attr_reg;

endmodule

[dv/video_scroll_address_unit_checker.sv]
`timescale 1ns / 1ps
// video_scroll_address_unit_checker: watches both channels of the scroll address unit,
// predicts every result from its own copy of the scroll state and compares; uses vsau_pkg

module video_scroll_address_unit_checker
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [vsau_pkg::OP_W-1:0]     operation,
    input  logic [vsau_pkg::SEL_W-1:0]    reg_select,
    input  logic [vsau_pkg::DATA_W-1:0]   write_data,

    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [vsau_pkg::ADDR_W-1:0]   current_address,
    input  logic [vsau_pkg::FINE_W-1:0]   fine_scroll_x,
    input  logic [vsau_pkg::ACCESS_W-1:0] data_access,
    input  logic [vsau_pkg::VADDR_W-1:0]  access_address,
    input  logic [vsau_pkg::DATA_W-1:0]   access_data,
    input  logic [vsau_pkg::VADDR_W-1:0]  tile_address,
    input  logic [vsau_pkg::VADDR_W-1:0]  attribute_address,

    output int                            mismatch_count,
    output int                            results_pending
);

    import vsau_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        addr_t                cur_addr;
        logic [FINE_W-1:0]    fine_x;
        logic [ACCESS_W-1:0]  access;
        vaddr_t               acc_addr;
        logic [DATA_W-1:0]    acc_data;
        vaddr_t               tile;
        vaddr_t               attr;
    } scroll_result_t;

    // shadow copy of the scroll state
    addr_t             shadow_vaddr  = '0;
    addr_t             temp_addr     = '0;
    logic [FINE_W-1:0] fine_x_shadow = '0;
    logic              write_latch   = 1'b0;
    logic              row_increment = 1'b0;
    logic [1:0]        render_on     = 2'b00;

    scroll_result_t    pending_scroll_results[$];
    scroll_result_t    seen_result;
    scroll_result_t    wanted_result;

    initial
    begin
        mismatch_count  = 0;
        results_pending = 0;
    end

    // data port access moves the address on by one or by a row
    function automatic addr_t advanced_address(input addr_t addr);
        return addr + (row_increment ? ROW_STEP : 15'd1);
    endfunction

    // one result as text for mismatch reports
    function automatic string result_text(input scroll_result_t r);
        return $sformatf("addr=%h fx=%0d acc=%0d aa=%h ad=%h tile=%h attr=%h",
                         r.cur_addr, r.fine_x, r.access, r.acc_addr, r.acc_data,
                         r.tile, r.attr);
    endfunction

    // applies one transaction to the shadow state and returns the expected result
    function automatic scroll_result_t predict_scroll_result(
        input logic [OP_W-1:0]   op,
        input logic [SEL_W-1:0]  sel,
        input logic [DATA_W-1:0] data
    );
        scroll_result_t r;
        r = '0;
        case (op)
            OP_REG_WRITE:
            begin
                case (sel)
                    REG_DATA:
                    begin
                        r.access     = ACCESS_WRITE;
                        r.acc_addr   = shadow_vaddr[VADDR_W-1:0];
                        r.acc_data   = data;
                        shadow_vaddr = advanced_address(shadow_vaddr);
                    end
                    REG_CONTROL:
                    begin
                        row_increment     = data[2];
                        temp_addr[11:10]  = data[1:0];
                    end
                    REG_MASK:
                        render_on = data[4:3];
                    REG_SCROLL:
                    begin
                        if (!write_latch)
                        begin
                            fine_x_shadow  = data[2:0];
                            temp_addr[4:0] = data[7:3];
                        end
                        else
                        begin
                            temp_addr[14:12] = data[2:0];
                            temp_addr[9:5]   = data[7:3];
                        end
                        write_latch = ~write_latch;
                    end
                    REG_ADDRESS:
                    begin
                        if (!write_latch)
                        begin
                            temp_addr[14]   = 1'b0;
                            temp_addr[13:8] = data[5:0];
                        end
                        else
                        begin
                            temp_addr[7:0] = data;
                            shadow_vaddr   = temp_addr;
                        end
                        write_latch = ~write_latch;
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_REG_READ:
            begin
                if (sel == REG_STATUS)
                    write_latch = 1'b0;
                else if (sel == REG_DATA)
                begin
                    r.access     = ACCESS_READ;
                    r.acc_addr   = shadow_vaddr[VADDR_W-1:0];
                    shadow_vaddr = advanced_address(shadow_vaddr);
                end
            end
            OP_COARSE_X:
            begin
                // coarse x wraps into the neighboring horizontal nametable
                if (render_on != 2'b00)
                begin
                    if (shadow_vaddr[4:0] == COARSE_MAX)
                    begin
                        shadow_vaddr[4:0] = '0;
                        shadow_vaddr[10]  = ~shadow_vaddr[10];
                    end
                    else
                        shadow_vaddr = shadow_vaddr + 15'd1;
                end
            end
            OP_STEP_Y:
            begin
                // fine y first, then coarse y with flip at 29 and plain wrap at 31
                if (render_on != 2'b00)
                begin
                    if (shadow_vaddr[14:12] != FINE_Y_MAX)
                        shadow_vaddr = shadow_vaddr + FINE_Y_ONE;
                    else
                    begin
                        shadow_vaddr[14:12] = '0;
                        if (shadow_vaddr[9:5] == COARSE_Y_NT)
                        begin
                            shadow_vaddr[9:5] = '0;
                            shadow_vaddr[11]  = ~shadow_vaddr[11];
                        end
                        else if (shadow_vaddr[9:5] == COARSE_MAX)
                            shadow_vaddr[9:5] = '0;
                        else
                            shadow_vaddr[9:5] = shadow_vaddr[9:5] + 5'd1;
                    end
                end
            end
            OP_COPY_HORIZ:
            begin
                if (render_on != 2'b00)
                    shadow_vaddr = (shadow_vaddr & ~HORIZ_BITS) | (temp_addr & HORIZ_BITS);
            end
            OP_COPY_VERT:
            begin
                if (render_on != 2'b00)
                    shadow_vaddr = (shadow_vaddr & ~VERT_BITS) | (temp_addr & VERT_BITS);
            end
            default:
            begin
            end
        endcase

        r.cur_addr = shadow_vaddr;
        r.fine_x   = fine_x_shadow;
        r.tile     = TILE_BASE | {2'b00, shadow_vaddr[11:0]};
        r.attr     = ATTR_BASE | {2'b00, shadow_vaddr[11:10], 10'b0}
                               | {8'b0, shadow_vaddr[9:7], shadow_vaddr[4:2]};
        return r;
    endfunction

    // compare delivered results, then record the prediction for a new transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_vaddr  = '0;
            temp_addr     = '0;
            fine_x_shadow = '0;
            write_latch   = 1'b0;
            row_increment = 1'b0;
            render_on     = 2'b00;
            pending_scroll_results.delete();
            results_pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen_result = {current_address, fine_scroll_x, data_access, access_address,
                               access_data, tile_address, attribute_address};
                if (pending_scroll_results.size() == 0)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: result with no transaction waiting: addr=%h",
                                 $realtime, current_address);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    wanted_result = pending_scroll_results.pop_front();
                    if (seen_result.cur_addr !== wanted_result.cur_addr
                        || seen_result.fine_x !== wanted_result.fine_x
                        || seen_result.access !== wanted_result.access
                        || seen_result.acc_addr !== wanted_result.acc_addr
                        || seen_result.acc_data !== wanted_result.acc_data
                        || seen_result.tile !== wanted_result.tile
                        || seen_result.attr !== wanted_result.attr)
                    begin
                        if (mismatch_count < REPORT_LIMIT)
                        begin
                            $display("%0t: mismatch expected %s",
                                     $realtime, result_text(wanted_result));
                            $display("%0t:          actual   %s",
                                     $realtime, result_text(seen_result));
                        end
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end

            if (in_valid && !in_stall)
                pending_scroll_results.push_back(
                    predict_scroll_result(operation, reg_select, write_data));

            results_pending <= pending_scroll_results.size();
        end
    end

endmodule

[dv/video_scroll_address_unit_test.sv]
`timescale 1ns / 1ps
// video_scroll_address_unit_test: stimulus and verdict for the scroll address unit;
// depends on vsau_pkg, video_scroll_address_unit and video_scroll_address_unit_checker

module video_scroll_address_unit_test;

    import vsau_pkg::*;

    // codes the block leaves unassigned
    localparam logic [OP_W-1:0]  OP_RESERVED_6 = 3'd6;
    localparam logic [OP_W-1:0]  OP_RESERVED_7 = 3'd7;
    localparam logic [SEL_W-1:0] REG_UNUSED_3  = 3'd3;
    localparam logic [SEL_W-1:0] REG_UNUSED_4  = 3'd4;

    localparam int RANDOM_ITEMS  = 850;
    localparam int IDLE_PERCENT  = 36;
    localparam int QUIET_START   = 500;
    localparam int QUIET_END     = 800;
    localparam int HOLD_START    = 300;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 8;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [OP_W-1:0]       operation  = '0;
    logic [SEL_W-1:0]      reg_select = '0;
    logic [DATA_W-1:0]     write_data = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [ADDR_W-1:0]     current_address;
    logic [FINE_W-1:0]     fine_scroll_x;
    logic [ACCESS_W-1:0]   data_access;
    logic [VADDR_W-1:0]    access_address;
    logic [DATA_W-1:0]     access_data;
    logic [VADDR_W-1:0]    tile_address;
    logic [VADDR_W-1:0]    attribute_address;

    int mismatch_count;
    int results_pending;
    int cycle_count = 0;
    int items_sent  = 0;

    video_scroll_address_unit u_dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .operation         (operation),
        .reg_select        (reg_select),
        .write_data        (write_data),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .current_address   (current_address),
        .fine_scroll_x     (fine_scroll_x),
        .data_access       (data_access),
        .access_address    (access_address),
        .access_data       (access_data),
        .tile_address      (tile_address),
        .attribute_address (attribute_address)
    );

    video_scroll_address_unit_checker u_checker
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .operation         (operation),
        .reg_select        (reg_select),
        .write_data        (write_data),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .current_address   (current_address),
        .fine_scroll_x     (fine_scroll_x),
        .data_access       (data_access),
        .access_address    (access_address),
        .access_data       (access_data),
        .tile_address      (tile_address),
        .attribute_address (attribute_address),
        .mismatch_count    (mismatch_count),
        .results_pending   (results_pending)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // random idling is switched off inside the quiet window
    function automatic logic idle_now();
        if (cycle_count >= QUIET_START && cycle_count < QUIET_END)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PERCENT;
    endfunction

    // offer one transaction and hold it until the block takes it
    task automatic send_item(
        input logic [OP_W-1:0]   op,
        input logic [SEL_W-1:0]  sel,
        input logic [DATA_W-1:0] data
    );
        while (idle_now())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        reg_select <= sel;
        write_data <= data;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // receiver: random stalls plus one long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (cycle_count == HOLD_START)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= idle_now();
        end
    end

    // run limit
    initial
    begin
        #1ms;
        $display("video_scroll_address_unit_test: errors");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        int burst;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: rendering off, then wraps of every address field
        send_item(OP_REG_READ,   REG_STATUS,  8'h00);
        send_item(OP_COARSE_X,   REG_CONTROL, 8'hFF);
        send_item(OP_COPY_VERT,  REG_CONTROL, 8'hFF);
        send_item(OP_REG_WRITE,  REG_MASK,    8'h18);
        send_item(OP_REG_WRITE,  REG_ADDRESS, 8'hFF);
        send_item(OP_REG_WRITE,  REG_ADDRESS, 8'hFF);
        send_item(OP_REG_WRITE,  REG_SCROLL,  8'hFF);
        send_item(OP_REG_WRITE,  REG_SCROLL,  8'hFF);
        send_item(OP_COPY_VERT,  REG_CONTROL, 8'h00);
        send_item(OP_REG_READ,   REG_DATA,    8'h00);
        send_item(OP_REG_WRITE,  REG_CONTROL, 8'hFF);
        send_item(OP_REG_WRITE,  REG_DATA,    8'hA5);
        send_item(OP_COPY_HORIZ, REG_CONTROL, 8'h00);
        send_item(OP_COARSE_X,   REG_CONTROL, 8'h00);
        send_item(OP_REG_WRITE,  REG_SCROLL,  8'h00);
        send_item(OP_REG_WRITE,  REG_SCROLL,  8'hEF);
        send_item(OP_COPY_VERT,  REG_CONTROL, 8'h00);
        send_item(OP_STEP_Y,     REG_CONTROL, 8'h00);
        send_item(OP_REG_WRITE,  REG_SCROLL,  8'h00);
        send_item(OP_REG_WRITE,  REG_SCROLL,  8'hFF);
        send_item(OP_COPY_VERT,  REG_CONTROL, 8'h00);
        send_item(OP_STEP_Y,     REG_CONTROL, 8'h00);
        send_item(OP_STEP_Y,     REG_CONTROL, 8'h00);
        send_item(OP_REG_WRITE,  REG_CONTROL, 8'h00);
        send_item(OP_RESERVED_6, REG_DATA,    8'hFF);
        send_item(OP_REG_WRITE,  REG_UNUSED_4, 8'hFF);
        send_item(OP_REG_READ,   REG_UNUSED_3, 8'hFF);
        send_item(OP_RESERVED_7, REG_UNUSED_3, 8'h00);

        // random: mostly well-formed register sequences and render events
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    // scroll pair, usually after a toggle reset
                    if ($urandom_range(0, 3) != 0)
                        send_item(OP_REG_READ, REG_STATUS, DATA_W'($urandom_range(0, 255)));
                    send_item(OP_REG_WRITE, REG_SCROLL, DATA_W'($urandom_range(0, 255)));
                    send_item(OP_REG_WRITE, REG_SCROLL, DATA_W'($urandom_range(0, 255)));
                end
                2:
                begin
                    // address pair followed by data port traffic
                    if ($urandom_range(0, 3) != 0)
                        send_item(OP_REG_READ, REG_STATUS, DATA_W'($urandom_range(0, 255)));
                    send_item(OP_REG_WRITE, REG_ADDRESS, DATA_W'($urandom_range(0, 255)));
                    send_item(OP_REG_WRITE, REG_ADDRESS, DATA_W'($urandom_range(0, 255)));
                    burst = $urandom_range(0, 4);
                    repeat (burst)
                        send_item($urandom_range(0, 1) ? OP_REG_WRITE : OP_REG_READ,
                                  REG_DATA, DATA_W'($urandom_range(0, 255)));
                end
                3:
                begin
                    // control and mask settings
                    send_item(OP_REG_WRITE, REG_CONTROL, DATA_W'($urandom_range(0, 255)));
                    send_item(OP_REG_WRITE, REG_MASK, DATA_W'($urandom_range(0, 255)));
                end
                4, 5, 6:
                begin
                    // render events
                    burst = $urandom_range(1, 8);
                    repeat (burst)
                        send_item(OP_W'($urandom_range(OP_COARSE_X, OP_COPY_VERT)),
                                  SEL_W'($urandom_range(0, 7)),
                                  DATA_W'($urandom_range(0, 255)));
                end
                7:
                begin
                    burst = $urandom_range(1, 6);
                    repeat (burst)
                        send_item($urandom_range(0, 1) ? OP_REG_WRITE : OP_REG_READ,
                                  REG_DATA, DATA_W'($urandom_range(0, 255)));
                end
                default:
                begin
                    // noise over the whole field space
                    burst = $urandom_range(1, 3);
                    repeat (burst)
                        send_item(OP_W'($urandom_range(0, 7)), SEL_W'($urandom_range(0, 7)),
                                  DATA_W'($urandom_range(0, 255)));
                end
            endcase
        end
        in_valid <= 1'b0;

        // drain
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && results_pending == 0)
            $display("video_scroll_address_unit_test: clean");
        else
            $display("video_scroll_address_unit_test: errors");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/vsau_pkg.sv
hw/rtl/video_scroll_address_unit.sv
dv/video_scroll_address_unit_checker.sv
dv/video_scroll_address_unit_test.sv
